// ===== hdl/dnle_pkg.sv =====
// shared types and constants of the dns name label encoder
package dnle_pkg;

  localparam int LABEL_LIMIT = 63;
  localparam int FILL_W      = $clog2(LABEL_LIMIT + 1);
  localparam int TOTAL_W     = 9;
  localparam int MAX_W       = 8;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_EMPTY      = 2'd1,
    ERR_LONG_LABEL = 2'd2,
    ERR_LONG_NAME  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ERROR,
    ACT_FLUSH
  } action_t;

  typedef enum logic [1:0] {
    OUT_ERR,
    OUT_LEN,
    OUT_DATA
  } out_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_LEN,
    S_DATA
  } state_t;

  typedef struct packed {
    logic     take;
    logic     load;
    out_sel_t sel;
    logic     advance;
  } cmd_t;

  typedef struct packed {
    logic    in_fire;
    action_t action;
    logic    slot_free;
    logic    last_data;
  } status_t;

endpackage

// ===== hdl/dnle_in_if.sv =====
// input channel: one character of the dotted name per item
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final;

  modport source(output valid, output char_in, output is_final, input ready);
  modport sink(input valid, input char_in, input is_final, output ready);
endinterface

// ===== hdl/dnle_out_if.sv =====
// output channel: one encoded byte per item
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       is_length;
  logic       last_of_run;
  logic       name_end;
  logic [1:0] error_code;

  modport source(output valid, output byte_out, output is_length, output last_of_run,
                 output name_end, output error_code, input ready);
  modport sink(input valid, input byte_out, input is_length, input last_of_run,
               input name_end, input error_code, output ready);
endinterface

// ===== hdl/dnle_ctrl.sv =====
// controller state machine of the dns name label encoder
module dnle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  dnle_pkg::status_t status,
  output dnle_pkg::cmd_t    cmd
);
  import dnle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (status.in_fire) begin
          unique case (status.action)
            ACT_ERROR: state_next = S_ERR;
            ACT_FLUSH: state_next = S_LEN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ERR: begin
        if (status.slot_free) state_next = S_IDLE;
      end
      S_LEN: begin
        if (status.slot_free) state_next = S_DATA;
      end
      S_DATA: begin
        if (status.slot_free && status.last_data) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.take    = 1'b0;
    cmd.load    = 1'b0;
    cmd.sel     = OUT_ERR;
    cmd.advance = 1'b0;
    unique case (state)
      S_IDLE: cmd.take = 1'b1;
      S_ERR: begin
        cmd.load = status.slot_free;
        cmd.sel  = OUT_ERR;
      end
      S_LEN: begin
        cmd.load = status.slot_free;
        cmd.sel  = OUT_LEN;
      end
      S_DATA: begin
        cmd.load    = status.slot_free;
        cmd.sel     = OUT_DATA;
        cmd.advance = status.slot_free;
      end
      default: cmd.take = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  // a flush always starts with the length byte
  a_flush_to_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && status.in_fire && status.action == ACT_FLUSH) |=> state == S_LEN)
    else $error("flush did not start with a length byte");

  // no new item while a run is being emitted
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.take)
    else $error("input taken during emission");

  // a stalled data byte keeps the machine in place
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA && !status.slot_free) |=> state == S_DATA)
    else $error("data state left while stalled");
`endif

endmodule

// ===== hdl/dnle_dpath.sv =====
// datapath: label memory, counters, error latch and output register
module dnle_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dnle_pkg::MAX_W-1:0] max_len,
  input  dnle_pkg::cmd_t             cmd,
  output dnle_pkg::status_t          status,
  dnle_in_if.sink                    name_chars,
  dnle_out_if.source                 wire_bytes
);
  import dnle_pkg::*;

  // label memory
  logic [7:0] label_mem [LABEL_LIMIT];
  logic [7:0] rd_data;

  // name state
  logic [FILL_W-1:0]  fill;
  logic [TOTAL_W-1:0] total;
  err_t               latch;

  // run being emitted
  logic [FILL_W-1:0] run_len;
  logic [FILL_W-1:0] rd_idx;
  logic [FILL_W-1:0] rd_idx_next;
  logic              pend_fin;
  err_t              pend_code;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_len;
  logic       out_last;
  logic       out_end;
  err_t       out_err;

  // item decode
  logic              in_fire;
  logic              dot;
  logic [FILL_W-1:0] n_eff;
  logic [TOTAL_W:0]  sum;
  logic              over;
  logic              store_ok;
  action_t           action;
  err_t              code;
  logic              slot_free;
  logic              last_data;

  assign in_fire  = cmd.take && name_chars.valid;
  assign dot      = (name_chars.char_in == DOT_CHAR);
  assign n_eff    = dot ? fill : fill + FILL_W'(1);
  assign sum      = (TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(n_eff) + (TOTAL_W + 1)'(1);
  assign over     = sum > (TOTAL_W + 1)'(max_len);
  assign store_ok = (latch == ERR_NONE) && !dot && (fill < FILL_W'(LABEL_LIMIT));

  always_comb begin
    action = ACT_NONE;
    code   = ERR_NONE;
    priority if (latch != ERR_NONE) begin
      if (name_chars.is_final) begin
        action = ACT_ERROR;
        code   = latch;
      end
    end else if (dot) begin
      priority if (fill == '0) begin
        action = ACT_ERROR;
        code   = ERR_EMPTY;
      end else if (over) begin
        action = ACT_ERROR;
        code   = ERR_LONG_NAME;
      end else begin
        action = ACT_FLUSH;
      end
    end else if (fill >= FILL_W'(LABEL_LIMIT)) begin
      action = ACT_ERROR;
      code   = ERR_LONG_LABEL;
    end else if (name_chars.is_final) begin
      if (over) begin
        action = ACT_ERROR;
        code   = ERR_LONG_NAME;
      end else begin
        action = ACT_FLUSH;
      end
    end else begin
      action = ACT_NONE;
    end
  end

  assign slot_free = !out_valid || wire_bytes.ready;
  assign last_data = (rd_idx == run_len - FILL_W'(1));

  assign status.in_fire   = in_fire;
  assign status.action    = action;
  assign status.slot_free = slot_free;
  assign status.last_data = last_data;

  assign name_chars.ready = cmd.take;

  // read address follows the next index so rd_data matches rd_idx during emission
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.take) begin
      rd_idx_next = '0;
    end else if (cmd.advance) begin
      rd_idx_next = rd_idx + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      label_mem[fill] <= name_chars.char_in;
    end
    if (rd_idx_next < FILL_W'(LABEL_LIMIT)) begin
      rd_data <= label_mem[rd_idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      total  <= '0;
      latch  <= ERR_NONE;
      rd_idx <= '0;
    end else begin
      rd_idx <= rd_idx_next;
      if (in_fire) begin
        unique case (action)
          ACT_ERROR: begin
            fill  <= '0;
            total <= '0;
            latch <= name_chars.is_final ? ERR_NONE : code;
          end
          ACT_FLUSH: begin
            fill  <= '0;
            total <= name_chars.is_final ? '0 : sum[TOTAL_W-1:0];
          end
          default: begin
            if (store_ok) fill <= fill + FILL_W'(1);
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      run_len   <= n_eff;
      pend_fin  <= name_chars.is_final;
      pend_code <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (wire_bytes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.sel)
        OUT_ERR: begin
          out_byte <= 8'd0;
          out_len  <= 1'b0;
          out_last <= 1'b1;
          out_end  <= pend_fin;
          out_err  <= pend_code;
        end
        OUT_LEN: begin
          out_byte <= 8'(run_len);
          out_len  <= 1'b1;
          out_last <= 1'b0;
          out_end  <= 1'b0;
          out_err  <= ERR_NONE;
        end
        default: begin
          out_byte <= rd_data;
          out_len  <= 1'b0;
          out_last <= last_data;
          out_end  <= last_data && pend_fin;
          out_err  <= ERR_NONE;
        end
      endcase
    end
  end

  assign wire_bytes.valid       = out_valid;
  assign wire_bytes.byte_out    = out_byte;
  assign wire_bytes.is_length   = out_len;
  assign wire_bytes.last_of_run = out_last;
  assign wire_bytes.name_end    = out_end;
  assign wire_bytes.error_code  = out_err;

`ifndef SYNTHESIS
  // an accepted flush leaves the label buffer empty
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_FLUSH) |=> fill == '0)
    else $error("label buffer not cleared by flush");

  // an error clears the buffer and the running count
  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && action == ACT_ERROR) |=> (fill == '0 && total == '0))
    else $error("error did not clear name state");

  // data bytes are only read inside the buffered label
  a_read_in_label: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> rd_idx < run_len)
    else $error("label read past its end");

  // a load never overwrites an item not yet taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> slot_free)
    else $error("output register overwritten");
`endif

endmodule

// ===== hdl/dns_name_label_encoder.sv =====
// top level of the dns name label encoder: config register and unit wiring
//
// Turns a dotted domain name, one character item at a time, into DNS wire-format
// labels: each label comes out as its length byte followed by its characters, and
// the last byte of the name carries name_end; no root byte is emitted. An ordinary
// character item is taken and produces nothing. A dot, or the final character, is
// accepted and its n-character label is sent as a length byte plus n bytes,
// one byte a cycle while the output is not stalled, from the single read port of
// the label memory; an error item is accepted and then gives one result item.
// Empty labels (error 1), labels over 63 characters (error 2) and names whose
// encoded length would exceed max_encoded_length (error 3) give one error item;
// after an error in mid-name all items up to the final one are dropped and the
// final one repeats the code. The label memory needs no clearing after reset.
// max_encoded_length sits at APB byte address 0, resets to 255, and should
// only be written while the block is idle.
module dns_name_label_encoder (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item channels
  dnle_in_if.sink     name_chars,
  dnle_out_if.source  wire_bytes
);
  import dnle_pkg::*;

  // configured limit on the encoded name length
  logic [MAX_W-1:0] max_len;
  logic             cfg_write;

  cmd_t    cmd;
  status_t status;

  // single register at address 0, other offsets read zero and ignore writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata    = (paddr == 2'd0) ? 32'(max_len) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_W'(255);
    end else if (cfg_write) begin
      max_len <= pwdata[MAX_W-1:0];
    end
  end

  // sequencer: accept, then error, length and data emission states
  dnle_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // label memory, counters and output register
  dnle_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .max_len    (max_len),
    .cmd        (cmd),
    .status     (status),
    .name_chars (name_chars),
    .wire_bytes (wire_bytes)
  );

endmodule
